FILE: src/hcfd_pkg.sv
// Package for the sync-header frame deframer.
// Holds the state encodings, register indexes and fixed widths; no dependencies.
package hcfd_pkg;

  // Receive phase of the frame parser.
  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_DATA   = 2'd2,
    PH_CHECK  = 2'd3
  } phase_t;

  // Sequencer state: receiving, or walking the stored frame to emit items.
  typedef enum logic [1:0] {
    ST_RECV    = 2'd0,
    ST_READ    = 2'd1,
    ST_COLLECT = 2'd2,
    ST_OUT     = 2'd3
  } seq_state_t;

  // Configuration register indexes.
  localparam logic REG_FIRST_SYNC  = 1'b0;
  localparam logic REG_SECOND_SYNC = 1'b1;

  localparam logic [7:0] FIRST_SYNC_RST  = 8'hfe;
  localparam logic [7:0] SECOND_SYNC_RST = 8'hfd;
  localparam logic [8:0] SUM_GOOD        = 9'd255;

  // Item counter covers up to 63 buttons plus 16 axes; payload position
  // covers the frame length and every item byte offset.
  localparam int ITEM_W = 7;
  localparam int POS_W  = 8;
  localparam int IDX_W  = 5;
  localparam int VAL_W  = 32;

endpackage

FILE: src/hcfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the deframer's payload store.
module hcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/header_checksum_frame_deframer_top.sv
// Top level of the two-byte sync frame deframer with additive checksum.
// Depends on hcfd_pkg and hcfd_ram.

// The block takes one serial byte per input word and accepts a byte every
// cycle while it parses a frame: hunt for the first sync byte, check the
// second, store FRAME_BYTES payload bytes while summing them modulo 256, then
// test the checksum byte (sum plus checksum must equal 255). A good frame
// produces BUTTON_COUNT button words and then AXIS_COUNT axis words; a bad one
// produces nothing. While the words of a good frame are produced the input is
// not ready. Every payload byte comes out of the store through its single
// registered read port, one byte per read: a button word takes one read and
// an axis word four, each read followed by a collect step, and the word is
// then offered until the output takes it.
module header_checksum_frame_deframer_top #(
  parameter int FRAME_BYTES  = 31,
  parameter int BUTTON_COUNT = 15,
  parameter int AXIS_COUNT   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Output stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] item_index, [36:5] item_value, [39:37] zero
  output logic        out_tuser,  // [0] is_axis
  output logic        out_tlast
);

  localparam int AW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int CW    = $clog2(FRAME_BYTES + 1);
  localparam int IW    = hcfd_pkg::ITEM_W;
  localparam int PW    = hcfd_pkg::POS_W;
  localparam int XW    = hcfd_pkg::IDX_W;
  localparam int VW    = hcfd_pkg::VAL_W;
  localparam int TOTAL = BUTTON_COUNT + AXIS_COUNT;

  localparam logic [CW-1:0] CNT_LAST   = CW'(FRAME_BYTES - 1);
  localparam logic [PW-1:0] FRAME_LIM  = PW'(FRAME_BYTES);
  localparam logic [IW-1:0] BTN_LIM    = IW'(BUTTON_COUNT);
  localparam logic [IW-1:0] ITEM_LAST  = IW'((TOTAL > 0) ? TOTAL - 1 : 0);
  localparam bit            HAS_ITEMS  = (TOTAL > 0);

  hcfd_pkg::phase_t     phase_r, phase_nxt;
  hcfd_pkg::seq_state_t st_r, st_nxt;

  logic [7:0]    first_sync_r, second_sync_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [IW-1:0] item_r, item_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [1:0]    lane_r, lane_nxt;
  logic          oob_r, oob_nxt;
  logic [VW-1:0] value_r, value_nxt;

  logic          ram_we;
  logic [7:0]    ram_rd_data;
  logic [7:0]    rd_byte;
  logic          is_axis;
  logic          is_last;

  hcfd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_addr (pos_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign is_axis = (item_r >= BTN_LIM);
  assign is_last = (item_r == ITEM_LAST);
  // Byte positions past the end of the payload read as zero.
  assign rd_byte = oob_r ? 8'd0 : ram_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r  <= hcfd_pkg::FIRST_SYNC_RST;
      second_sync_r <= hcfd_pkg::SECOND_SYNC_RST;
    end else if (cfg_wr_en) begin
      if (cfg_addr == hcfd_pkg::REG_FIRST_SYNC) begin
        first_sync_r <= cfg_wdata;
      end
      if (cfg_addr == hcfd_pkg::REG_SECOND_SYNC) begin
        second_sync_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcfd_pkg::PH_HUNT;
      st_r    <= hcfd_pkg::ST_RECV;
      cnt_r   <= '0;
      sum_r   <= '0;
      item_r  <= '0;
      pos_r   <= '0;
      lane_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      item_r  <= item_nxt;
      pos_r   <= pos_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oob_r   <= oob_nxt;
    value_r <= value_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    item_nxt  = item_r;
    pos_nxt   = pos_r;
    lane_nxt  = lane_r;
    oob_nxt   = oob_r;
    value_nxt = value_r;
    ram_we    = 1'b0;
    in_tready = 1'b0;

    case (st_r)
      hcfd_pkg::ST_RECV: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (phase_r)
            hcfd_pkg::PH_HUNT: begin
              if (in_tdata == first_sync_r) begin
                phase_nxt = hcfd_pkg::PH_SECOND;
              end
            end
            hcfd_pkg::PH_SECOND: begin
              // A wrong second byte is dropped, not retried as a first sync.
              if (in_tdata == second_sync_r) begin
                phase_nxt = hcfd_pkg::PH_DATA;
                cnt_nxt   = '0;
                sum_nxt   = '0;
              end else begin
                phase_nxt = hcfd_pkg::PH_HUNT;
              end
            end
            hcfd_pkg::PH_DATA: begin
              ram_we  = 1'b1;
              sum_nxt = sum_r + in_tdata;
              cnt_nxt = cnt_r + 1'b1;
              if (cnt_r == CNT_LAST) begin
                phase_nxt = hcfd_pkg::PH_CHECK;
              end
            end
            default: begin
              phase_nxt = hcfd_pkg::PH_HUNT;
              // The check is on the unwrapped 9-bit sum.
              if (({1'b0, sum_r} + {1'b0, in_tdata}) == hcfd_pkg::SUM_GOOD && HAS_ITEMS) begin
                st_nxt    = hcfd_pkg::ST_READ;
                item_nxt  = '0;
                pos_nxt   = '0;
                lane_nxt  = '0;
                value_nxt = '0;
              end
            end
          endcase
        end
      end
      hcfd_pkg::ST_READ: begin
        // The store is addressed by pos_r; its data arrives next cycle.
        oob_nxt = (pos_r >= FRAME_LIM);
        pos_nxt = pos_r + 1'b1;
        st_nxt  = hcfd_pkg::ST_COLLECT;
      end
      hcfd_pkg::ST_COLLECT: begin
        value_nxt[{lane_r, 3'b000} +: 8] = rd_byte;
        if (!is_axis || lane_r == 2'd3) begin
          st_nxt = hcfd_pkg::ST_OUT;
        end else begin
          lane_nxt = lane_r + 1'b1;
          st_nxt   = hcfd_pkg::ST_READ;
        end
      end
      hcfd_pkg::ST_OUT: begin
        if (out_tready) begin
          if (is_last) begin
            st_nxt = hcfd_pkg::ST_RECV;
          end else begin
            item_nxt  = item_r + 1'b1;
            lane_nxt  = '0;
            value_nxt = '0;
            st_nxt    = hcfd_pkg::ST_READ;
          end
        end
      end
      default: begin
        st_nxt = hcfd_pkg::ST_RECV;
      end
    endcase
  end

  assign out_tvalid = (st_r == hcfd_pkg::ST_OUT);
  assign out_tdata  = {3'b000, value_r, item_r[XW-1:0]};
  assign out_tuser  = is_axis;
  assign out_tlast  = is_last;

endmodule

FILE: dv/testbench.sv
// Testbench for header_checksum_frame_deframer_top: random and directed serial bytes with
// idle, stall and back-pressure phases, checked against a predictor of the frame parser.
// Depends on hcfd_pkg and the deframer RTL.
module testbench;

  localparam int FRAME_BYTES  = 31;
  localparam int BUTTON_COUNT = 15;
  localparam int AXIS_COUNT   = 4;
  localparam int RANDOM_BYTES = 20;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic [4:0]  index;
    logic        is_axis;
    logic [31:0] value;
    logic        last;
  } frame_word_t;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_ALT} fill_t;

  // Predicts the words of each frame and checks the words that come out.
  class frame_scoreboard;
    hcfd_pkg::phase_t parse_phase;
    int unsigned   stored;
    logic [7:0]    sum;
    logic [7:0]    payload [FRAME_BYTES];
    logic [7:0]    sync_a;
    logic [7:0]    sync_b;
    frame_word_t   expected_q[$];
    int unsigned   errors;
    int unsigned   words_checked;
    int unsigned   good_frames;

    function new();
      parse_phase = hcfd_pkg::PH_HUNT;
      stored = 0;
      sum = 8'h00;
      sync_a = hcfd_pkg::FIRST_SYNC_RST;
      sync_b = hcfd_pkg::SECOND_SYNC_RST;
      foreach (payload[i]) payload[i] = 8'h00;
    endfunction

    function void set_reg(logic idx, logic [7:0] v);
      if (idx == hcfd_pkg::REG_FIRST_SYNC) sync_a = v;
      else sync_b = v;
    endfunction

    function logic [7:0] byte_at(int unsigned pos);
      return (pos < FRAME_BYTES) ? payload[pos] : 8'h00;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      frame_word_t w;
      int unsigned base;
      int unsigned total;
      total = BUTTON_COUNT + AXIS_COUNT;
      case (parse_phase)
        hcfd_pkg::PH_HUNT: begin
          if (b == sync_a) parse_phase = hcfd_pkg::PH_SECOND;
        end
        hcfd_pkg::PH_SECOND: begin
          // A wrong second byte is dropped, even when it equals the first sync byte.
          if (b == sync_b) begin
            parse_phase = hcfd_pkg::PH_DATA;
            stored = 0;
            sum = 8'h00;
          end else begin
            parse_phase = hcfd_pkg::PH_HUNT;
          end
        end
        hcfd_pkg::PH_DATA: begin
          if (stored < FRAME_BYTES) payload[stored] = b;
          sum = sum + b;
          stored++;
          if (stored >= FRAME_BYTES) parse_phase = hcfd_pkg::PH_CHECK;
        end
        default: begin
          parse_phase = hcfd_pkg::PH_HUNT;
          if ({1'b0, sum} + {1'b0, b} == hcfd_pkg::SUM_GOOD) begin
            good_frames++;
            for (int unsigned i = 0; i < BUTTON_COUNT; i++) begin
              w.index   = 5'(i);
              w.is_axis = 1'b0;
              w.value   = {24'h0, byte_at(i)};
              w.last    = (i + 1 == total);
              expected_q = {expected_q, w};
            end
            for (int unsigned k = 0; k < AXIS_COUNT; k++) begin
              base      = BUTTON_COUNT + 4 * k;
              w.index   = 5'(BUTTON_COUNT + k);
              w.is_axis = 1'b1;
              w.value   = {byte_at(base + 3), byte_at(base + 2), byte_at(base + 1),
                           byte_at(base)};
              w.last    = (BUTTON_COUNT + k + 1 == total);
              expected_q = {expected_q, w};
            end
          end
        end
      endcase
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t exp_w;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: index %0d axis %0b value %h last %0b",
                   got.index, got.is_axis, got.value, got.last);
        return;
      end
      exp_w = expected_q.pop_front();
      words_checked++;
      if (got.index !== exp_w.index || got.is_axis !== exp_w.is_axis ||
          got.value !== exp_w.value || got.last !== exp_w.last) begin
        errors++;
        if (errors <= 10) begin
          $display("word mismatch: expected index %0d axis %0b value %h last %0b",
                   exp_w.index, exp_w.is_axis, exp_w.value, exp_w.last);
          $display("               got      index %0d axis %0b value %h last %0b",
                   got.index, got.is_axis, got.value, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_addr = hcfd_pkg::REG_FIRST_SYNC;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // [4:0] item_index, [36:5] item_value, [39:37] zero
  logic        out_tuser;          // [0] is_axis
  logic        out_tlast;

  frame_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycles = 0;

  header_checksum_frame_deframer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    frame_word_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.index   = out_tdata[4:0];
        got.value   = out_tdata[36:5];
        got.is_axis = out_tuser;
        got.last    = out_tlast;
        sb.check_word(got);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A checksum of ck_err = 0 makes the frame good; anything else breaks it.
  task automatic send_frame(input fill_t fill, input logic [7:0] ck_err);
    logic [7:0] b;
    logic [7:0] s;
    s = 8'h00;
    send_byte(sb.sync_a);
    send_byte(sb.sync_b);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hff;
        FILL_ALT:  b = i[0] ? 8'h55 : 8'haa;
        default:   b = 8'($urandom_range(0, 255));
      endcase
      s = s + b;
      send_byte(b);
    end
    send_byte(~s + ck_err);
  endtask

  // Walks the parser back to hunting without producing any words.
  task automatic flush_parser();
    while (sb.parse_phase != hcfd_pkg::PH_HUNT) begin
      case (sb.parse_phase)
        hcfd_pkg::PH_SECOND: send_byte(sb.sync_b ^ 8'h01);
        hcfd_pkg::PH_DATA:   send_byte(8'h00);
        default:             send_byte(~sb.sum ^ 8'h01);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic next_phase(input logic [7:0] sync_a, input logic [7:0] sync_b,
                            input int unsigned idle_pct, input int unsigned stall_pct);
    flush_parser();
    stop_sending();
    wait_drained();
    write_reg(hcfd_pkg::REG_FIRST_SYNC, sync_a);
    write_reg(hcfd_pkg::REG_SECOND_SYNC, sync_b);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(($urandom_range(9) == 0) ? fill_t'($urandom_range(1, 3)) : FILL_RANDOM,
                   8'h00);
      end else if (pick < 78) begin
        send_frame(FILL_RANDOM, 8'($urandom_range(1, 255)));
      end else if (pick < 90) begin
        send_byte(sb.sync_a);
        send_byte(sb.sync_b ^ 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset sync values and no idling.
    send_byte(8'h00);
    send_byte(8'hff);
    // First sync byte twice: the second one is a wrong second byte and is not
    // taken as a new start, so the following second sync byte is ignored too.
    send_byte(sb.sync_a);
    send_byte(sb.sync_a);
    send_byte(sb.sync_b);
    send_frame(FILL_ZERO, 8'h00);
    send_frame(FILL_ONES, 8'h00);
    send_frame(FILL_ALT, 8'h01);
    send_frame(FILL_ALT, 8'h00);

    // Long receiver hold-off while good frames keep coming.
    hold_request = 1'b1;
    repeat (3) send_frame(FILL_RANDOM, 8'h00);
    run_random(RANDOM_BYTES);

    next_phase(8'h00, 8'hff, 85, 0);
    run_random(RANDOM_BYTES);
    next_phase(8'hff, 8'h00, 0, 85);
    run_random(RANDOM_BYTES);
    // Equal sync bytes.
    next_phase(8'h5a, 8'h5a, 37, 37);
    run_random(RANDOM_BYTES);
    next_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 0);
    run_random(RANDOM_BYTES);

    stop_sending();
    wait_drained();
    $display("run covered %0d bytes, %0d good frames, %0d words checked, %0d register writes",
             bytes_sent, sb.good_frames, sb.words_checked, cfg_writes);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: header_checksum_frame_deframer_top.f
src/hcfd_pkg.sv
src/hcfd_ram.sv
src/header_checksum_frame_deframer_top.sv
dv/testbench.sv
